/* sv/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared command codes, widths and the structs that the sequencer passes to
// the bit shifter and to the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Byte geometry and counter widths.
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = $clog2(BITS_PER_BYTE);
  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned POLL_W        = 4;

  // Poll limit after reset.
  localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 4'd5;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_START = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEND  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RECV  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_NACK  = 3'd6;

  // Shifter controls issued by the sequencer.
  typedef struct packed {
    logic load;      // capture the command's byte fields
    logic tx_shift;  // move the transmit register one bit left
    logic rx_clear;  // clear the receive byte
    logic rx_shift;  // sample the next slave bit into the receive byte
  } shift_ctrl_t;

  // Line state after one phase.
  typedef struct packed {
    logic scl;
    logic sda;
    logic dir;
    logic failed;
    logic last;
  } phase_t;

endpackage

/* sv/i2cm_shift.sv */
// ----------------------------------------------------------------------------
// I2C master bit shifter
// Serializes the transmit byte and assembles the receive byte bit by bit,
// as the shift strobes from the sequencer direct.
// ----------------------------------------------------------------------------
module i2cm_shift (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  i2cm_pkg::shift_ctrl_t                 ctrl_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]    tx_byte_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]    slave_bits_i,
  output logic                                  tx_msb_o,
  output logic [i2cm_pkg::BITS_PER_BYTE-1:0]    rx_d_o
);

  localparam int unsigned W = i2cm_pkg::BITS_PER_BYTE;

  logic [W-1:0] tx_q, tx_d;
  logic [W-1:0] sb_q, sb_d;
  logic [W-1:0] rx_q, rx_d;

  // Transmit and slave-bit shift registers.
  always_comb begin
    tx_d = tx_q;
    sb_d = sb_q;
    if (ctrl_i.load) begin
      tx_d = tx_byte_i;
      sb_d = slave_bits_i;
    end else begin
      if (ctrl_i.tx_shift) begin
        tx_d = {tx_q[W-2:0], 1'b0};
      end
      if (ctrl_i.rx_shift) begin
        sb_d = {sb_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q <= tx_d;
    sb_q <= sb_d;
  end

  // Receive byte: cleared at the first bit, then one sampled bit per clock high.
  always_comb begin
    rx_d = rx_q;
    if (ctrl_i.rx_clear) begin
      rx_d = '0;
    end else if (ctrl_i.rx_shift) begin
      rx_d = {rx_q[W-2:0], sb_q[W-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q <= '0;
    end else begin
      rx_q <= rx_d;
    end
  end

  assign tx_msb_o = tx_q[W-1];
  assign rx_d_o   = rx_d;

endmodule

/* sv/i2cm_seq.sv */
// ----------------------------------------------------------------------------
// I2C master phase sequencer
// Steps through the line phases of one command, one phase per emitted beat,
// and keeps the bus line registers and the sticky failure flag.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [i2cm_pkg::FUNC_W-1:0]         func_i,
  input  logic [i2cm_pkg::POLL_W-1:0]         ack_delay_polls_i,
  input  logic [i2cm_pkg::POLL_W-1:0]         poll_limit_i,
  input  logic                                out_free_i,
  input  logic                                tx_msb_i,
  output logic                                emit_o,
  output i2cm_pkg::shift_ctrl_t               ctrl_o,
  output i2cm_pkg::phase_t                    phase_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ONE   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_STOP  = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;
  localparam logic [2:0] S_RECV  = 3'd5;
  localparam logic [2:0] S_WACK  = 3'd6;
  localparam logic [2:0] S_ANS   = 3'd7;

  localparam int unsigned BW = i2cm_pkg::BIT_CNT_W;
  localparam logic [BW-1:0] LAST_BIT = BW'(i2cm_pkg::BITS_PER_BYTE - 1);

  logic [2:0]    state_q, state_d;
  logic [2:0]    step_q, step_d;
  logic [BW-1:0] bit_q, bit_d;
  logic          nack_q, nack_d;
  logic          tmo_q, tmo_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic          dir_q, dir_d;
  logic          fail_q, fail_d;
  logic          last;
  logic          accept;
  logic          timeout;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit_o     = (state_q != S_IDLE) && out_free_i;

  // A zero limit stands for sixteen polls, which a 4-bit delay never reaches.
  assign timeout = (poll_limit_i != '0) && (ack_delay_polls_i >= poll_limit_i);

  // Phase stepping and line updates.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    nack_d  = nack_q;
    tmo_d   = tmo_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    dir_d   = dir_q;
    fail_d  = fail_q;
    last    = 1'b0;
    ctrl_o  = '0;

    if (accept) begin
      ctrl_o.load = 1'b1;
      step_d      = '0;
      bit_d       = '0;
      nack_d      = (func_i == i2cm_pkg::FUNC_NACK);
      tmo_d       = 1'b0;
      if (fail_q) begin
        state_d = S_ONE;
      end else begin
        unique case (func_i)
          i2cm_pkg::FUNC_START: state_d = S_START;
          i2cm_pkg::FUNC_STOP:  state_d = S_STOP;
          i2cm_pkg::FUNC_SEND:  state_d = S_SEND;
          i2cm_pkg::FUNC_RECV:  state_d = S_RECV;
          i2cm_pkg::FUNC_WACK: begin
            state_d = S_WACK;
            tmo_d   = timeout;
          end
          i2cm_pkg::FUNC_ACK:   state_d = S_ANS;
          i2cm_pkg::FUNC_NACK:  state_d = S_ANS;
          default:              state_d = S_ONE;
        endcase
      end
    end else if (emit_o) begin
      step_d = step_q + 3'd1;
      unique case (state_q)
        S_START: begin
          unique case (step_q)
            3'd0:    sda_d = 1'b1;
            3'd1:    scl_d = 1'b1;
            3'd2:    sda_d = 1'b0;
            default: begin
              scl_d = 1'b0;
              last  = 1'b1;
            end
          endcase
        end
        S_STOP: begin
          unique case (step_q)
            3'd0:    scl_d = 1'b0;
            3'd1:    sda_d = 1'b0;
            3'd2:    scl_d = 1'b1;
            default: begin
              sda_d = 1'b1;
              last  = 1'b1;
              if (tmo_q) begin
                fail_d = 1'b1;
              end
            end
          endcase
        end
        S_SEND: begin
          unique case (step_q)
            3'd0: scl_d = 1'b0;
            3'd1: begin
              sda_d           = tx_msb_i;
              ctrl_o.tx_shift = 1'b1;
            end
            3'd2: begin
              scl_d = 1'b1;
              if (bit_q != LAST_BIT) begin
                bit_d  = bit_q + BW'(1);
                step_d = 3'd0;
              end
            end
            default: begin
              scl_d = 1'b0;
              last  = 1'b1;
            end
          endcase
        end
        S_RECV: begin
          unique case (step_q)
            3'd0: dir_d = 1'b0;
            3'd1: begin
              scl_d = 1'b0;
              if (bit_q == '0) begin
                ctrl_o.rx_clear = 1'b1;
              end
            end
            3'd2: begin
              scl_d           = 1'b1;
              ctrl_o.rx_shift = 1'b1;
              if (bit_q != LAST_BIT) begin
                bit_d  = bit_q + BW'(1);
                step_d = 3'd1;
              end
            end
            3'd3: scl_d = 1'b0;
            default: begin
              dir_d = 1'b1;
              last  = 1'b1;
            end
          endcase
        end
        S_WACK: begin
          unique case (step_q)
            3'd0: dir_d = 1'b0;
            3'd1: scl_d = 1'b1;
            3'd2: begin
              dir_d = 1'b1;
              // A timed-out wait continues with a full stop sequence.
              if (tmo_q) begin
                state_d = S_STOP;
                step_d  = 3'd0;
              end
            end
            default: begin
              scl_d = 1'b0;
              last  = 1'b1;
            end
          endcase
        end
        S_ANS: begin
          unique case (step_q)
            3'd0:    sda_d = nack_q;
            3'd1:    scl_d = 1'b1;
            default: begin
              scl_d = 1'b0;
              last  = 1'b1;
            end
          endcase
        end
        default: begin
          // Failed bus or unknown command: one idle beat.
          last = 1'b1;
        end
      endcase
      if (last) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
      nack_q  <= 1'b0;
      tmo_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      dir_q   <= 1'b1;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      nack_q  <= nack_d;
      tmo_q   <= tmo_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      dir_q   <= dir_d;
      fail_q  <= fail_d;
    end
  end

  // Line state that the emitted beat reports.
  assign phase_o.scl    = scl_d;
  assign phase_o.sda    = sda_d;
  assign phase_o.dir    = dir_d;
  assign phase_o.failed = fail_d;
  assign phase_o.last   = last;

endmodule

/* sv/i2c_master_bit_engine_top.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine
// Single-bus I2C line sequencer: one command in, one result beat per line
// action out.
// ----------------------------------------------------------------------------
// A command is accepted only while the engine is idle. After acceptance the
// sequencer emits one line phase per clock cycle into the output register
// whenever the output slot is free; an output stall holds the sequencer.
// The bytes move through byte-wide shift registers that shift one bit at a time.
module i2c_master_bit_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [i2cm_pkg::FUNC_W-1:0]         func_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]  tx_byte_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]  slave_bits_i,
  input  logic [i2cm_pkg::POLL_W-1:0]         ack_delay_polls_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                scl_level_o,
  output logic                                sda_level_o,
  output logic                                sda_driven_o,
  output logic [i2cm_pkg::BITS_PER_BYTE-1:0]  rx_data_o,
  output logic                                bus_failed_o,
  output logic                                last_phase_o,
  // Configuration channel: ack poll limit.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [i2cm_pkg::POLL_W-1:0]         cfg_data_i
);

  logic [i2cm_pkg::POLL_W-1:0]        limit_q;
  logic                               out_valid_q;
  i2cm_pkg::phase_t                   phase_q;
  logic [i2cm_pkg::BITS_PER_BYTE-1:0] rx_q;
  logic                               out_free;
  logic                               emit;
  logic                               tx_msb;
  i2cm_pkg::shift_ctrl_t              ctrl;
  i2cm_pkg::phase_t                   phase;
  logic [i2cm_pkg::BITS_PER_BYTE-1:0] rx_d;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= i2cm_pkg::ACK_POLL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  i2cm_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .ack_delay_polls_i (ack_delay_polls_i),
    .poll_limit_i      (limit_q),
    .out_free_i        (out_free),
    .tx_msb_i          (tx_msb),
    .emit_o            (emit),
    .ctrl_o            (ctrl),
    .phase_o           (phase)
  );

  i2cm_shift u_shift (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .tx_byte_i    (tx_byte_i),
    .slave_bits_i (slave_bits_i),
    .tx_msb_o     (tx_msb),
    .rx_d_o       (rx_d)
  );

  // Output register: a new beat loads when the slot is empty or being taken.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      phase_q <= phase;
      rx_q    <= rx_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = phase_q.scl;
  assign sda_level_o  = phase_q.sda;
  assign sda_driven_o = phase_q.dir;
  assign rx_data_o    = rx_q;
  assign bus_failed_o = phase_q.failed;
  assign last_phase_o = phase_q.last;

endmodule

/* verif/i2c_master_bit_engine_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Watches the command, result and poll limit channels, keeps its own model
// of the bus lines, and compares every result beat with the oldest
// predicted line phase.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel.
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [i2cm_pkg::FUNC_W-1:0]         func_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]  tx_byte_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]  slave_bits_i,
  input  logic [i2cm_pkg::POLL_W-1:0]         ack_delay_polls_i,
  // Result channel.
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                scl_level_i,
  input  logic                                sda_level_i,
  input  logic                                sda_driven_i,
  input  logic [i2cm_pkg::BITS_PER_BYTE-1:0]  rx_data_i,
  input  logic                                bus_failed_i,
  input  logic                                last_phase_i,
  // Poll limit channel.
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [i2cm_pkg::POLL_W-1:0]         cfg_data_i,
  // Status toward the test top.
  output int unsigned                         err_cnt_o,
  output int unsigned                         pend_cnt_o
);

  // One predicted line phase.
  typedef struct packed {
    logic                               scl;
    logic                               sda;
    logic                               dir;
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] rx;
    logic                               failed;
    logic                               last;
  } line_beat_t;

  line_beat_t beat_q[$];
  line_beat_t seen_beat;
  line_beat_t want_beat;

  // Model of the bus lines and the poll limit.
  logic [i2cm_pkg::POLL_W-1:0]        poll_limit;
  logic                               bus_dead;
  logic                               scl_q;
  logic                               sda_q;
  logic                               dir_q;
  logic [i2cm_pkg::BITS_PER_BYTE-1:0] rx_shift;

  // Queue the line state as it stands after one action.
  function automatic void emit_phase();
    beat_q.push_back({scl_q, sda_q, dir_q, rx_shift, bus_dead, 1'b0});
  endfunction

  function automatic void set_scl(input logic v);
    scl_q = v;
    emit_phase();
  endfunction

  function automatic void set_sda(input logic v);
    sda_q = v;
    emit_phase();
  endfunction

  function automatic void set_dir(input logic v);
    dir_q = v;
    emit_phase();
  endfunction

  function automatic void stop_phases();
    set_scl(1'b0);
    set_sda(1'b0);
    set_scl(1'b1);
    set_sda(1'b1);
  endfunction

  // Mark the final phase of a command; it carries the flag as it now stands.
  function automatic void close_command();
    line_beat_t b;
    b = beat_q.pop_back();
    b.last   = 1'b1;
    b.failed = bus_dead;
    beat_q.push_back(b);
  endfunction

  // Work out every line phase that one command causes.
  function automatic void predict_command(
    input logic [i2cm_pkg::FUNC_W-1:0]        f,
    input logic [i2cm_pkg::BITS_PER_BYTE-1:0] tx,
    input logic [i2cm_pkg::BITS_PER_BYTE-1:0] sb,
    input logic [i2cm_pkg::POLL_W-1:0]        dly
  );
    int unsigned                        lim;
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] tx_w;
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] sb_w;
    tx_w = tx;
    sb_w = sb;
    if (bus_dead) begin
      emit_phase();
    end else begin
      case (f)
        i2cm_pkg::FUNC_START: begin
          set_sda(1'b1);
          set_scl(1'b1);
          set_sda(1'b0);
          set_scl(1'b0);
        end
        i2cm_pkg::FUNC_STOP: begin
          stop_phases();
        end
        i2cm_pkg::FUNC_SEND: begin
          for (int i = 0; i < i2cm_pkg::BITS_PER_BYTE; i++) begin
            set_scl(1'b0);
            set_sda(tx_w[i2cm_pkg::BITS_PER_BYTE-1]);
            tx_w = tx_w << 1;
            set_scl(1'b1);
          end
          set_scl(1'b0);
        end
        i2cm_pkg::FUNC_RECV: begin
          set_dir(1'b0);
          rx_shift = '0;
          for (int i = 0; i < i2cm_pkg::BITS_PER_BYTE; i++) begin
            set_scl(1'b0);
            scl_q    = 1'b1;
            rx_shift = {rx_shift[i2cm_pkg::BITS_PER_BYTE-2:0],
                        sb_w[i2cm_pkg::BITS_PER_BYTE-1]};
            sb_w     = sb_w << 1;
            emit_phase();
          end
          set_scl(1'b0);
          set_dir(1'b1);
        end
        i2cm_pkg::FUNC_WACK: begin
          // A zero limit stands for sixteen polls.
          lim = (poll_limit == '0) ? 16 : poll_limit;
          set_dir(1'b0);
          set_scl(1'b1);
          set_dir(1'b1);
          if (dly >= lim) begin
            // Ack timeout: stop the bus and latch the failure.
            stop_phases();
            bus_dead = 1'b1;
          end else begin
            set_scl(1'b0);
          end
        end
        i2cm_pkg::FUNC_ACK, i2cm_pkg::FUNC_NACK: begin
          set_sda(f == i2cm_pkg::FUNC_NACK);
          set_scl(1'b1);
          set_scl(1'b0);
        end
        default: begin
          // An unknown code leaves the lines alone.
          emit_phase();
        end
      endcase
    end
    close_command();
  endfunction

  function automatic void compare_field(
    input string                              tag,
    input logic [i2cm_pkg::BITS_PER_BYTE-1:0] want_v,
    input logic [i2cm_pkg::BITS_PER_BYTE-1:0] seen_v
  );
    if (want_v !== seen_v) begin
      $display("%0t ERROR: %s expected %0h got %0h", $time, tag, want_v, seen_v);
      err_cnt_o++;
    end
  endfunction

  // Compare result beats first, then predict newly accepted commands.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit = i2cm_pkg::ACK_POLL_LIMIT_RST;
      bus_dead   = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      dir_q      = 1'b1;
      rx_shift   = '0;
      beat_q.delete();
      err_cnt_o  = 0;
      pend_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_beat = {scl_level_i, sda_level_i, sda_driven_i, rx_data_i,
                     bus_failed_i, last_phase_i};
        if (beat_q.size() == 0) begin
          $display("%0t ERROR: result beat expected none got %0h", $time, seen_beat);
          err_cnt_o++;
        end else begin
          want_beat = beat_q.pop_front();
          compare_field("scl_level", want_beat.scl, seen_beat.scl);
          compare_field("sda_level", want_beat.sda, seen_beat.sda);
          compare_field("sda_driven", want_beat.dir, seen_beat.dir);
          compare_field("rx_data", want_beat.rx, seen_beat.rx);
          compare_field("bus_failed", want_beat.failed, seen_beat.failed);
          compare_field("last_phase", want_beat.last, seen_beat.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        poll_limit = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        predict_command(func_i, tx_byte_i, slave_bits_i, ack_delay_polls_i);
      end
      pend_cnt_o = beat_q.size();
    end
  end

endmodule

/* verif/i2c_master_bit_engine_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit engine test top
// Drives bus commands and poll limit writes into the engine under several
// idle and stall patterns, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top_test;

  localparam logic [i2cm_pkg::FUNC_W-1:0] FUNC_UNDEF  = 3'd7;
  localparam int unsigned                 WDOG_LIMIT  = 5000;
  localparam int unsigned                 PHASE_ITEMS = 100;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [i2cm_pkg::FUNC_W-1:0]        func_i;
  logic [i2cm_pkg::BITS_PER_BYTE-1:0] tx_byte_i;
  logic [i2cm_pkg::BITS_PER_BYTE-1:0] slave_bits_i;
  logic [i2cm_pkg::POLL_W-1:0]        ack_delay_polls_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic                               scl_level_o;
  logic                               sda_level_o;
  logic                               sda_driven_o;
  logic [i2cm_pkg::BITS_PER_BYTE-1:0] rx_data_o;
  logic                               bus_failed_o;
  logic                               last_phase_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [i2cm_pkg::POLL_W-1:0]        cfg_data_i;

  int unsigned                 err_cnt;
  int unsigned                 pend_cnt;
  int unsigned                 idle_pct;
  int unsigned                 stall_pct;
  int unsigned                 phase_items;
  int unsigned                 wdog_cnt;
  logic [i2cm_pkg::POLL_W-1:0] cur_limit;

  i2c_master_bit_engine_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .tx_byte_i         (tx_byte_i),
    .slave_bits_i      (slave_bits_i),
    .ack_delay_polls_i (ack_delay_polls_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .scl_level_o       (scl_level_o),
    .sda_level_o       (sda_level_o),
    .sda_driven_o      (sda_driven_o),
    .rx_data_o         (rx_data_o),
    .bus_failed_o      (bus_failed_o),
    .last_phase_o      (last_phase_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i)
  );

  i2c_master_bit_engine_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .func_i            (func_i),
    .tx_byte_i         (tx_byte_i),
    .slave_bits_i      (slave_bits_i),
    .ack_delay_polls_i (ack_delay_polls_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .scl_level_i       (scl_level_o),
    .sda_level_i       (sda_level_o),
    .sda_driven_i      (sda_driven_o),
    .rx_data_i         (rx_data_o),
    .bus_failed_i      (bus_failed_o),
    .last_phase_i      (last_phase_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .err_cnt_o         (err_cnt),
    .pend_cnt_o        (pend_cnt)
  );

  // Free-running clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // The result side stalls at random, with the rate set per phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too many cycles without any beat on any channel ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      wdog_cnt = 0;
    end else begin
      wdog_cnt++;
    end
    if (wdog_cnt >= WDOG_LIMIT) begin
      $display("%0t ERROR: no beat for %0d cycles", $time, wdog_cnt);
      $display("i2c_master_bit_engine_top_test NOT OK");
      $finish;
    end
  end

  // Offer one command beat, with a random gap ahead of it.
  task automatic push_cmd(
    input logic [i2cm_pkg::FUNC_W-1:0]        f,
    input logic [i2cm_pkg::BITS_PER_BYTE-1:0] tx,
    input logic [i2cm_pkg::BITS_PER_BYTE-1:0] sb,
    input logic [i2cm_pkg::POLL_W-1:0]        dly
  );
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid_i        <= 1'b1;
    func_i            <= f;
    tx_byte_i         <= tx;
    slave_bits_i      <= sb;
    ack_delay_polls_i <= dly;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    phase_items++;
  endtask

  // Drop the command valid and move to the next falling edge.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold off until every predicted beat has come back.
  task automatic drain();
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the poll limit while the engine is idle.
  task automatic write_poll_limit(input logic [i2cm_pkg::POLL_W-1:0] v);
    quiesce();
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_limit = v;
  endtask

  // Pick a poll count that the current limit still accepts.
  function automatic logic [i2cm_pkg::POLL_W-1:0] safe_delay();
    int unsigned lim;
    lim = (cur_limit == '0) ? 16 : cur_limit;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [i2cm_pkg::BITS_PER_BYTE-1:0] rnd_byte();
    return $urandom_range(0, 255);
  endfunction

  // One bus transaction: start, address, data bytes with acks, and mostly a stop.
  task automatic random_transfer();
    logic [i2cm_pkg::BITS_PER_BYTE-1:0] addr;
    int unsigned                        n_bytes;
    addr    = rnd_byte();
    n_bytes = $urandom_range(1, 4);
    push_cmd(i2cm_pkg::FUNC_START, rnd_byte(), rnd_byte(), $urandom_range(0, 15));
    push_cmd(i2cm_pkg::FUNC_SEND, addr, rnd_byte(), $urandom_range(0, 15));
    push_cmd(i2cm_pkg::FUNC_WACK, rnd_byte(), rnd_byte(), safe_delay());
    for (int i = 0; i < n_bytes; i++) begin
      if (addr[0]) begin
        push_cmd(i2cm_pkg::FUNC_RECV, rnd_byte(), rnd_byte(), $urandom_range(0, 15));
        push_cmd((i == n_bytes - 1) ? i2cm_pkg::FUNC_NACK : i2cm_pkg::FUNC_ACK,
                 rnd_byte(), rnd_byte(), $urandom_range(0, 15));
      end else begin
        push_cmd(i2cm_pkg::FUNC_SEND, rnd_byte(), rnd_byte(), $urandom_range(0, 15));
        push_cmd(i2cm_pkg::FUNC_WACK, rnd_byte(), rnd_byte(), safe_delay());
      end
    end
    // Now and then the stop is left out, which gives a repeated start.
    if ($urandom_range(0, 9) != 0) begin
      push_cmd(i2cm_pkg::FUNC_STOP, rnd_byte(), rnd_byte(), $urandom_range(0, 15));
    end
  endtask

  // A single command of any code; an ack wait never times out here.
  task automatic random_noise();
    logic [i2cm_pkg::FUNC_W-1:0] f;
    f = $urandom_range(0, 7);
    push_cmd(f, rnd_byte(), rnd_byte(),
             (f == i2cm_pkg::FUNC_WACK) ? safe_delay() : $urandom_range(0, 15));
  endtask

  // Poll limit, idle and stall rates of each random phase.
  task automatic set_phase(input int p);
    case (p)
      0: begin write_poll_limit(4'd15); idle_pct = 0;  stall_pct = 0;  end
      1: begin write_poll_limit(4'd1);  idle_pct = 76; stall_pct = 0;  end
      2: begin write_poll_limit(4'd0);  idle_pct = 0;  stall_pct = 76; end
      3: begin write_poll_limit(4'd9);  idle_pct = 31; stall_pct = 31; end
      default: begin write_poll_limit(4'd12); idle_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // Stimulus and verdict.
  initial begin
    int paused;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    func_i            = i2cm_pkg::FUNC_START;
    tx_byte_i         = '0;
    slave_bits_i      = '0;
    ack_delay_polls_i = '0;
    out_ready_i       = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    phase_items       = 0;
    wdog_cnt          = 0;
    cur_limit         = i2cm_pkg::ACK_POLL_LIMIT_RST;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part under the reset poll limit: byte extremes and every code.
    push_cmd(i2cm_pkg::FUNC_START, 8'h00, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_SEND,  8'h00, 8'hFF, 4'd15);
    push_cmd(i2cm_pkg::FUNC_WACK,  8'hFF, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_SEND,  8'hFF, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_WACK,  8'h00, 8'h00, i2cm_pkg::ACK_POLL_LIMIT_RST - 4'd1);
    push_cmd(i2cm_pkg::FUNC_SEND,  8'hA5, 8'h5A, 4'd3);
    push_cmd(i2cm_pkg::FUNC_ACK,   8'hFF, 8'hFF, 4'd15);
    push_cmd(i2cm_pkg::FUNC_RECV,  8'h00, 8'hFF, 4'd15);
    push_cmd(i2cm_pkg::FUNC_NACK,  8'h00, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_RECV,  8'hFF, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_ACK,   8'h00, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_RECV,  8'hFF, 8'h5A, 4'd10);
    push_cmd(i2cm_pkg::FUNC_NACK,  8'hFF, 8'hFF, 4'd15);
    push_cmd(FUNC_UNDEF,           8'hFF, 8'hFF, 4'd15);
    push_cmd(i2cm_pkg::FUNC_STOP,  8'h00, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_STOP,  8'hFF, 8'hFF, 4'd15);
    push_cmd(i2cm_pkg::FUNC_START, 8'hFF, 8'hFF, 4'd15);
    push_cmd(i2cm_pkg::FUNC_START, 8'h00, 8'h00, 4'd0);

    // A zero limit wraps to sixteen polls, so even the longest delay acks.
    write_poll_limit(4'd0);
    push_cmd(i2cm_pkg::FUNC_WACK, 8'h3C, 8'hC3, 4'd15);
    write_poll_limit(4'd15);
    push_cmd(i2cm_pkg::FUNC_WACK, 8'h3C, 8'hC3, 4'd14);
    write_poll_limit(4'd1);
    push_cmd(i2cm_pkg::FUNC_WACK, 8'h3C, 8'hC3, 4'd0);
    push_cmd(i2cm_pkg::FUNC_STOP, 8'h00, 8'h00, 4'd0);

    // Random phases, each with one pause until all results are back.
    for (int p = 0; p < 5; p++) begin
      set_phase(p);
      phase_items = 0;
      paused      = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (paused == 0 && phase_items >= PHASE_ITEMS / 2) begin
          quiesce();
          drain();
          paused = 1;
        end
        if ($urandom_range(0, 99) < 85) begin
          random_transfer();
        end else begin
          random_noise();
        end
      end
    end

    // Ack timeout at the limit, then commands on the failed bus.
    write_poll_limit(4'd3);
    idle_pct  = 31;
    stall_pct = 31;
    push_cmd(i2cm_pkg::FUNC_START, 8'h55, 8'hAA, 4'd0);
    push_cmd(i2cm_pkg::FUNC_SEND,  8'h55, 8'hAA, 4'd0);
    push_cmd(i2cm_pkg::FUNC_WACK,  8'h55, 8'hAA, 4'd3);
    push_cmd(i2cm_pkg::FUNC_START, 8'h55, 8'hAA, 4'd0);
    push_cmd(i2cm_pkg::FUNC_SEND,  8'hFF, 8'hFF, 4'd0);
    push_cmd(i2cm_pkg::FUNC_RECV,  8'hFF, 8'hFF, 4'd0);
    push_cmd(i2cm_pkg::FUNC_WACK,  8'h00, 8'h00, 4'd0);
    push_cmd(FUNC_UNDEF,           8'h00, 8'h00, 4'd0);
    push_cmd(i2cm_pkg::FUNC_STOP,  8'h00, 8'h00, 4'd0);

    // Let every result drain, then allow a margin for stray beats.
    quiesce();
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (pend_cnt != 0) begin
      $display("%0t ERROR: %0d result beats never arrived", $time, pend_cnt);
    end
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("i2c_master_bit_engine_top_test OK");
    end else begin
      $display("i2c_master_bit_engine_top_test NOT OK");
    end
    $finish;
  end

endmodule

/* i2c_master_bit_engine_top.f */
sv/i2cm_pkg.sv
sv/i2cm_shift.sv
sv/i2cm_seq.sv
sv/i2c_master_bit_engine_top.sv
verif/i2c_master_bit_engine_checker.sv
verif/i2c_master_bit_engine_top_test.sv
